/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SMC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Same check with a message of its own.
`define SMC_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

/* rtl/smc_pkg.sv */
// Types, codes and helpers shared by the stack machine executor.
package smc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CmdW  = 4;
  localparam int unsigned KindW = 2;
  localparam int unsigned ErrW  = 3;

  // Instruction opcodes; the remaining codes are invalid.
  typedef enum logic [CmdW-1:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_MUL   = 4'd2,
    CMD_DIV   = 4'd3,
    CMD_PUSH  = 4'd4,
    CMD_PRINT = 4'd5,
    CMD_DROP  = 4'd6,
    CMD_DUP   = 4'd7,
    CMD_SWAP  = 4'd8,
    CMD_ROT   = 4'd9,
    CMD_DUMP  = 4'd10
  } cmd_e;

  // Result kinds.
  typedef enum logic [KindW-1:0] {
    KIND_DONE  = 2'd0,
    KIND_PRINT = 2'd1,
    KIND_DUMP  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  // Error codes.
  typedef enum logic [ErrW-1:0] {
    ERR_NONE      = 3'd0,
    ERR_UNDERFLOW = 3'd1,
    ERR_OVERFLOW  = 3'd2,
    ERR_DIVZERO   = 3'd3,
    ERR_INVALID   = 3'd4,
    ERR_HALTED    = 3'd5
  } err_e;

  // What one cell takes on the next edge.
  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_UP,    // from the neighbor nearer the top
    SEL_DOWN,  // from the neighbor nearer the bottom
    SEL_LOAD
  } cell_sel_e;

  // Whole-chain moves, decoded per cell.
  typedef enum logic [2:0] {
    CH_HOLD,
    CH_PUSH,
    CH_POP,
    CH_POPLOAD,
    CH_DUP,
    CH_SWAP,
    CH_ROT
  } chain_op_e;

  typedef struct packed {
    cell_sel_e        sel;
    logic [DataW-1:0] load;
  } cell_ctl_t;

  // Decode a chain move into the select of the cell at depth idx (0 is top).
  function automatic cell_sel_e cell_sel(chain_op_e op, int unsigned idx);
    cell_sel_e sel;
    sel = SEL_HOLD;
    unique case (op)
      CH_HOLD:    sel = SEL_HOLD;
      CH_PUSH:    sel = (idx == 0) ? SEL_LOAD : SEL_UP;
      CH_POP:     sel = SEL_DOWN;
      CH_POPLOAD: sel = (idx == 0) ? SEL_LOAD : SEL_DOWN;
      CH_DUP:     sel = (idx == 0) ? SEL_HOLD : SEL_UP;
      CH_SWAP:    sel = (idx == 0) ? SEL_DOWN : ((idx == 1) ? SEL_UP : SEL_HOLD);
      CH_ROT:     sel = (idx == 0 || idx == 2) ? SEL_LOAD : SEL_HOLD;
      default:    sel = SEL_HOLD;
    endcase
    return sel;
  endfunction

endpackage

/* rtl/smc_cell.sv */
// One stack cell: holds one entry and moves it with its neighbors.
module smc_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  smc_pkg::cell_ctl_t           ctl_i,
  input  logic [smc_pkg::DataW-1:0]    up_i,
  input  logic [smc_pkg::DataW-1:0]    down_i,
  output logic [smc_pkg::DataW-1:0]    value_o
);
  import smc_pkg::*;

  logic [DataW-1:0] value_d, value_q;

  // Pick the next entry from the cell itself, a neighbor or the load bus.
  always_comb begin
    unique case (ctl_i.sel)
      SEL_HOLD: value_d = value_q;
      SEL_UP:   value_d = up_i;
      SEL_DOWN: value_d = down_i;
      SEL_LOAD: value_d = ctl_i.load;
      default:  value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

/* rtl/smc_div.sv */
// Radix-2 restoring divider for signed 32-bit operands, truncating.
module smc_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [smc_pkg::DataW-1:0]    dividend_i,
  input  logic [smc_pkg::DataW-1:0]    divisor_i,
  output logic                         busy_o,
  output logic [smc_pkg::DataW-1:0]    quotient_o
);
  import smc_pkg::*;

  localparam int unsigned StepW = $clog2(DataW + 1);

  logic             busy_d, busy_q;
  logic [StepW-1:0] step_d, step_q;
  logic [DataW-1:0] rem_d, rem_q;
  logic [DataW-1:0] quo_d, quo_q;
  logic [DataW-1:0] dvs_q;
  logic             neg_q;
  logic [DataW:0]   rem_sh;
  logic             fits;
  logic [DataW-1:0] dvd_abs, dvs_abs;

  // Magnitudes of the operands.
  assign dvd_abs = dividend_i[DataW-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign dvs_abs = divisor_i[DataW-1]  ? (~divisor_i + 1'b1)  : divisor_i;

  // One quotient bit per cycle.
  assign rem_sh = {rem_q, quo_q[DataW-1]};
  assign fits   = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = StepW'(DataW);
      rem_d  = '0;
      quo_d  = dvd_abs;
    end else if (busy_q) begin
      rem_d  = fits ? DataW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DataW-1:0];
      quo_d  = {quo_q[DataW-2:0], fits};
      step_d = step_q - 1'b1;
      busy_d = (step_q != StepW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= dvs_abs;
      neg_q <= dividend_i[DataW-1] ^ divisor_i[DataW-1];
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

/* rtl/stack_machine_executor.sv */
// Top level of the stack machine executor: sequencer, stack cell chain, result register.
//
//  channel  | dir | tdata                          | tuser          | tlast
//  ---------+-----+--------------------------------+----------------+---------------
//  s_axis   | in  | [31:0] immediate               | [3:0] cmd      | -
//  m_axis   | out | [31:0] data, [34:32] error_code| [1:0] kind     | last of request
//
// A request is accepted in S_IDLE and executed on the cell chain in S_EXEC. Multiply
// adds S_MUL for the registered product; divide waits in S_DIV on the bit-serial
// divider; dump gives one result per cycle unless stalled, one per stack entry.
// Reset leaves the stack holding a single zero; no clearing pass is needed.
// A full result register stalls execution until the result is taken; a new request
// is accepted only once the previous one has handed over its last result.
`include "assert_macros.svh"

module stack_machine_executor #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] immediate
  input  logic [3:0]  s_axis_tuser,   // [3:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] data, [34:32] error_code, [39:35] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last
);
  import smc_pkg::*;

  localparam int unsigned IdxW = $clog2(STACK_DEPTH);
  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_DUMP
  } state_e;

  state_e           state_d, state_q;
  logic [CntW-1:0]  cnt_d, cnt_q;
  logic             halted_d, halted_q;
  logic [IdxW-1:0]  ptr_d, ptr_q;
  logic [CmdW-1:0]  cmd_q;
  logic [DataW-1:0] imm_q;
  logic [DataW-1:0] prod_q;
  logic [DataW-1:0] prod_lo;

  logic             out_free;
  logic             emit;
  kind_e            e_kind;
  logic [DataW-1:0] e_data;
  logic             e_last;
  err_e             e_err;

  logic             m_valid_q;
  kind_e            m_kind_q;
  logic [DataW-1:0] m_data_q;
  logic             m_last_q;
  err_e             m_err_q;

  chain_op_e        chain_op;
  logic [DataW-1:0] ld0;
  logic             div_start;
  logic             div_busy;
  logic [DataW-1:0] div_quo;

  logic [DataW-1:0] cell_val  [STACK_DEPTH];
  logic [DataW-1:0] up_val    [STACK_DEPTH];
  logic [DataW-1:0] down_val  [STACK_DEPTH];
  cell_ctl_t        cell_ctl  [STACK_DEPTH];

  // Stack cell chain, top of stack in cell zero.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_top
      assign up_val[i] = '0;
    end else begin : g_mid
      assign up_val[i] = cell_val[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign down_val[i] = '0;
    end else begin : g_inner
      assign down_val[i] = cell_val[i+1];
    end
    assign cell_ctl[i].sel  = cell_sel(chain_op, i);
    assign cell_ctl[i].load = (i == 2) ? cell_val[0] : ld0;

    smc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (cell_ctl[i]),
      .up_i    (up_val[i]),
      .down_i  (down_val[i]),
      .value_o (cell_val[i])
    );
  end

  smc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cell_val[1]),
    .divisor_i  (cell_val[0]),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // Low word of second times top.
  assign prod_lo  = DataW'(cell_val[1] * cell_val[0]);
  assign out_free = !m_valid_q || m_axis_tready;

  // Sequencer: decode, check, move the chain and build the result.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    halted_d  = halted_q;
    ptr_d     = ptr_q;
    chain_op  = CH_HOLD;
    ld0       = '0;
    div_start = 1'b0;
    emit      = 1'b0;
    e_kind    = KIND_DONE;
    e_data    = '0;
    e_last    = 1'b1;
    e_err     = ERR_NONE;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          emit = 1'b1;
          if (halted_q) begin
            e_kind = KIND_ERROR;
            e_err  = ERR_HALTED;
          end else begin
            unique case (cmd_q)
              CMD_ADD, CMD_SUB: begin
                if (cnt_q < CntW'(2)) begin
                  e_kind = KIND_ERROR;
                  e_err  = ERR_UNDERFLOW;
                end else begin
                  chain_op = CH_POPLOAD;
                  ld0      = (cmd_q == CMD_ADD) ? (cell_val[1] + cell_val[0])
                                                : (cell_val[1] - cell_val[0]);
                  cnt_d    = cnt_q - 1'b1;
                end
              end
              CMD_MUL: begin
                if (cnt_q < CntW'(2)) begin
                  e_kind = KIND_ERROR;
                  e_err  = ERR_UNDERFLOW;
                end else begin
                  emit = 1'b0;
                end
              end
              CMD_DIV: begin
                if (cnt_q < CntW'(2)) begin
                  e_kind = KIND_ERROR;
                  e_err  = ERR_UNDERFLOW;
                end else if (cell_val[0] == '0) begin
                  e_kind = KIND_ERROR;
                  e_err  = ERR_DIVZERO;
                end else begin
                  emit      = 1'b0;
                  div_start = 1'b1;
                end
              end
              CMD_PUSH: begin
                if (cnt_q >= CntW'(STACK_DEPTH)) begin
                  e_kind = KIND_ERROR;
                  e_err  = ERR_OVERFLOW;
                end else begin
                  chain_op = CH_PUSH;
                  ld0      = imm_q;
                  cnt_d    = cnt_q + 1'b1;
                end
              end
              CMD_PRINT: begin
                if (cnt_q == '0) begin
                  e_kind = KIND_ERROR;
                  e_err  = ERR_UNDERFLOW;
                end else begin
                  chain_op = CH_POP;
                  cnt_d    = cnt_q - 1'b1;
                  e_kind   = KIND_PRINT;
                  e_data   = cell_val[0];
                end
              end
              CMD_DROP: begin
                if (cnt_q == '0) begin
                  e_kind = KIND_ERROR;
                  e_err  = ERR_UNDERFLOW;
                end else begin
                  chain_op = CH_POP;
                  cnt_d    = cnt_q - 1'b1;
                end
              end
              CMD_DUP: begin
                if (cnt_q == '0) begin
                  e_kind = KIND_ERROR;
                  e_err  = ERR_UNDERFLOW;
                end else if (cnt_q >= CntW'(STACK_DEPTH)) begin
                  e_kind = KIND_ERROR;
                  e_err  = ERR_OVERFLOW;
                end else begin
                  chain_op = CH_DUP;
                  cnt_d    = cnt_q + 1'b1;
                end
              end
              CMD_SWAP: begin
                if (cnt_q < CntW'(2)) begin
                  e_kind = KIND_ERROR;
                  e_err  = ERR_UNDERFLOW;
                end else begin
                  chain_op = CH_SWAP;
                end
              end
              CMD_ROT: begin
                if (cnt_q < CntW'(3)) begin
                  e_kind = KIND_ERROR;
                  e_err  = ERR_UNDERFLOW;
                end else begin
                  chain_op = CH_ROT;
                  ld0      = cell_val[2];
                end
              end
              CMD_DUMP: begin
                halted_d = 1'b1;
                if (cnt_q == '0) begin
                  e_kind = KIND_DUMP;
                end else begin
                  emit  = 1'b0;
                  ptr_d = IdxW'(cnt_q - 1'b1);
                end
              end
              default: begin
                halted_d = 1'b1;
                e_kind   = KIND_ERROR;
                e_err    = ERR_INVALID;
              end
            endcase
          end
          if (emit) begin
            state_d = S_IDLE;
          end else if (div_start) begin
            state_d = S_DIV;
          end else if (halted_d) begin
            state_d = S_DUMP;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (out_free) begin
          emit     = 1'b1;
          chain_op = CH_POPLOAD;
          ld0      = prod_q;
          cnt_d    = cnt_q - 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_DIV: begin
        if (!div_busy && out_free) begin
          emit     = 1'b1;
          chain_op = CH_POPLOAD;
          ld0      = div_quo;
          cnt_d    = cnt_q - 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_DUMP: begin
        // Walk from the bottom entry up to the top.
        if (out_free) begin
          emit   = 1'b1;
          e_kind = KIND_DUMP;
          e_data = cell_val[ptr_q];
          e_last = (ptr_q == '0);
          if (ptr_q == '0) begin
            state_d = S_IDLE;
          end else begin
            ptr_d = ptr_q - 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= CntW'(1);
      halted_q  <= 1'b0;
      ptr_q     <= '0;
      m_valid_q <= 1'b0;
      m_kind_q  <= KIND_DONE;
      m_data_q  <= '0;
      m_last_q  <= 1'b0;
      m_err_q   <= ERR_NONE;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      halted_q <= halted_d;
      ptr_q    <= ptr_d;
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (emit) begin
        m_kind_q <= e_kind;
        m_data_q <= e_data;
        m_last_q <= e_last;
        m_err_q  <= e_err;
      end
    end
  end

  // Payload registers: request fields and product.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid) begin
      cmd_q <= s_axis_tuser;
      imm_q <= s_axis_tdata;
    end
    if (state_q == S_EXEC) begin
      prod_q <= prod_lo;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'd0, m_err_q, m_data_q};
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tlast  = m_last_q;

  `SMC_ASSERT(a_cnt_bound, cnt_q <= CntW'(STACK_DEPTH))
  `SMC_ASSERT_MSG(a_halt_sticks, halted_q |=> halted_q, "halt flag cleared")
  `SMC_ASSERT_MSG(a_div_owned, div_busy |-> state_q == S_DIV, "divider busy outside divide")
  `SMC_ASSERT(a_idle_keeps_cnt, state_q == S_IDLE |=> $stable(cnt_q))

endmodule
